// ----- sv/pst_pkg.sv -----
// Package for the process identifier slot tracker.
// Holds the table size, field widths, the word types and the sequencer state type.
// No dependencies; every other file of the block imports it.
package pst_pkg;

  // Table size and derived widths.
  localparam int SLOTS      = 64;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int CNT_W      = $clog2(SLOTS + 1);
  localparam int IDENT_W    = 15;
  localparam int SLOT_OUT_W = 6;
  localparam int CNT_OUT_W  = 7;

  // Item kinds carried in the action field.
  typedef enum logic {
    ACT_OBSERVE = 1'b0,
    ACT_SWEEP   = 1'b1
  } action_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_e;

  // Input word.
  typedef struct packed {
    action_e              action;
    logic [IDENT_W-1:0]   ident;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic [SLOT_OUT_W-1:0] slot;
    logic                  is_new;
    logic                  ignored;
    logic                  full_res;
    logic [CNT_OUT_W-1:0]  removed_count;
    logic [CNT_OUT_W-1:0]  high_water;
  } out_word_t;

  // Contents of one slot cell.
  typedef struct packed {
    logic [IDENT_W-1:0] ident;
    logic               seen;
  } cell_t;

  // Control that the sequencer sends to the row of cells.
  typedef struct packed {
    logic              shift;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_idx;
    cell_t             wr_word;
  } cell_ctl_t;

endpackage

// ----- sv/pst_if.sv -----
// Handshake channels of the slot tracker: one for input words, one for result words.
// Depends on pst_pkg for the word types.

interface pst_in_if import pst_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pst_out_if import pst_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/pst_cell.sv -----
// One slot cell of the rotating slot table: holds an identifier and its seen mark.
// Depends on pst_pkg for the cell word type.
module pst_cell import pst_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  shift_i,
  input  logic  load_i,
  input  cell_t next_i,
  input  cell_t load_word_i,
  output cell_t q_o
);

  cell_t word_q;

  // A direct write wins; otherwise the cell takes its neighbor's word on a shift.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
    end else if (load_i) begin
      word_q <= load_word_i;
    end else if (shift_i) begin
      word_q <= next_i;
    end
  end

  assign q_o = word_q;

endmodule

// ----- sv/pst_ctrl.sv -----
// Sequencer of the slot tracker: watches the head cell while the table rotates once,
// updates the word that re-enters at the tail, keeps the mark and drives the result register.
// Depends on pst_pkg and the pst_in_if and pst_out_if channels.
module pst_ctrl import pst_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  pst_in_if.sink    in_i,
  pst_out_if.source out_o,
  input  cell_t     head_i,
  output cell_t     tail_o,
  output cell_ctl_t ctl_o
);

  state_e             state_q, state_d;
  action_e            act_q, act_d;
  logic [IDENT_W-1:0] ident_q, ident_d;
  logic               zero_q, zero_d;
  logic [SLOT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]   mark_q, mark_d;
  logic               hit_found_q, hit_found_d;
  logic [SLOT_W-1:0]  hit_idx_q, hit_idx_d;
  logic               free_found_q, free_found_d;
  logic [SLOT_W-1:0]  free_idx_q, free_idx_d;
  logic [CNT_W-1:0]   removed_q, removed_d;
  logic               top_free_q, top_free_d;
  logic               out_valid_q, out_valid_d;
  out_word_t          out_q, out_d;

  logic               accept;
  logic               out_free;
  logic               last;
  logic               below;
  logic               match;
  logic               kill;
  logic               in_zero;

  assign accept   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign last     = (cnt_q == SLOT_W'(SLOTS - 1));
  assign below    = (CNT_W'(cnt_q) < mark_q);
  assign match    = below && (head_i.ident == ident_q);
  assign kill     = below && !head_i.seen && (head_i.ident != '0);
  assign in_zero  = (in_i.data.action == ACT_OBSERVE) && (in_i.data.ident == '0);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = in_zero ? S_FINISH : S_SCAN;
        end
      end
      S_SCAN: begin
        if (last) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Input handshake.
  always_comb begin
    in_i.ready = (state_q == S_IDLE);
  end

  // Word that re-enters the row at the tail during a rotation.
  always_comb begin
    tail_o = head_i;
    if (act_q == ACT_SWEEP) begin
      tail_o.seen = 1'b0;
      if (kill) begin
        tail_o.ident = '0;
      end
    end else if (match) begin
      tail_o.seen = 1'b1;
    end
  end

  // Rotation control, scan bookkeeping, final update and the result register.
  always_comb begin
    act_d         = act_q;
    ident_d       = ident_q;
    zero_d        = zero_q;
    cnt_d         = cnt_q;
    mark_d        = mark_q;
    hit_found_d   = hit_found_q;
    hit_idx_d     = hit_idx_q;
    free_found_d  = free_found_q;
    free_idx_d    = free_idx_q;
    removed_d     = removed_q;
    top_free_d    = top_free_q;
    out_d         = out_q;
    out_valid_d   = out_valid_q && !out_o.ready;
    ctl_o.shift   = (state_q == S_SCAN);
    ctl_o.wr_en   = 1'b0;
    ctl_o.wr_idx  = free_idx_q;
    ctl_o.wr_word = '{ident: ident_q, seen: 1'b1};

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          act_d        = in_i.data.action;
          ident_d      = in_i.data.ident;
          zero_d       = in_zero;
          cnt_d        = '0;
          hit_found_d  = 1'b0;
          free_found_d = 1'b0;
          removed_d    = '0;
          top_free_d   = 1'b0;
        end
      end
      S_SCAN: begin
        cnt_d = last ? '0 : cnt_q + SLOT_W'(1);
        if (act_q == ACT_SWEEP) begin
          if (kill) begin
            removed_d = removed_q + CNT_W'(1);
          end
          // Remember whether the top slot in use ends up free.
          if ((mark_q != '0) && (CNT_W'(cnt_q) == mark_q - CNT_W'(1))) begin
            top_free_d = (tail_o.ident == '0);
          end
        end else begin
          if (match && !hit_found_q) begin
            hit_found_d = 1'b1;
            hit_idx_d   = cnt_q;
          end
          if (below && (head_i.ident == '0) && !free_found_q) begin
            free_found_d = 1'b1;
            free_idx_d   = cnt_q;
          end
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '0;
          if (zero_q) begin
            out_d.ignored = 1'b1;
          end else if (act_q == ACT_SWEEP) begin
            out_d.removed_count = CNT_OUT_W'(removed_q);
            if ((mark_q != '0) && top_free_q) begin
              mark_d = mark_q - CNT_W'(1);
            end
          end else if (hit_found_q) begin
            out_d.slot = SLOT_OUT_W'(hit_idx_q);
          end else if (free_found_q) begin
            ctl_o.wr_en   = 1'b1;
            ctl_o.wr_idx  = free_idx_q;
            out_d.slot    = SLOT_OUT_W'(free_idx_q);
            out_d.is_new  = 1'b1;
          end else if (mark_q < CNT_W'(SLOTS)) begin
            // Append a slot at the mark and raise the mark.
            ctl_o.wr_en   = 1'b1;
            ctl_o.wr_idx  = SLOT_W'(mark_q);
            out_d.slot    = SLOT_OUT_W'(mark_q);
            out_d.is_new  = 1'b1;
            mark_d        = mark_q + CNT_W'(1);
          end else begin
            out_d.full_res = 1'b1;
          end
          out_d.high_water = CNT_OUT_W'(mark_d);
        end
      end
      default: begin
        cnt_d = '0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      mark_q       <= '0;
      hit_found_q  <= 1'b0;
      free_found_q <= 1'b0;
      zero_q       <= 1'b0;
      act_q        <= ACT_OBSERVE;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      mark_q       <= mark_d;
      hit_found_q  <= hit_found_d;
      free_found_q <= free_found_d;
      zero_q       <= zero_d;
      act_q        <= act_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    ident_q    <= ident_d;
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
    removed_q  <= removed_d;
    top_free_q <= top_free_d;
    out_q      <= out_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // The rotation counter rests at zero outside a scan.
  a_cnt_rest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_SCAN) |-> (cnt_q == '0))
    else $error("rotation counter not at rest outside a scan");

  // The mark never passes the table size.
  a_mark_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mark_q <= CNT_W'(SLOTS))
    else $error("mark above table size");

  // A finished item is delivered to the result register once it is free.
  a_finish_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH && out_free) |=> out_valid_q)
    else $error("finished item not loaded into result register");

  // A full result is only reported with the table at its size.
  a_full_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.full_res) |-> (mark_q == CNT_W'(SLOTS)))
    else $error("full reported below table size");

endmodule

// ----- sv/pid_slot_tracker.sv -----
// Process identifier slot tracker: a row of SLOTS slot cells that rotates once per item
// (zero observe words apart), with a sequencer that looks at the head cell each cycle
// and rewrites the tail. Depends on pst_pkg, pst_if, pst_cell and pst_ctrl.
//
// An observe word with a nonzero identifier or an end-of-scan word is accepted in the
// idle state, then the scan state turns the cell row once, and the finishing state
// writes a placed identifier and loads the result register. An observe word with
// identifier zero skips the turn: the finishing state loads its result with the
// ignored flag. A new word is accepted only in the idle state, after the previous word
// has finished. The result register keeps a finished word while the next word is
// accepted and worked on; the sequencer holds in its finishing state only if that
// earlier word has still not been taken.
module pid_slot_tracker import pst_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  pst_in_if.sink    in_i,
  pst_out_if.source out_o
);

  cell_t       cell_q [SLOTS];
  cell_t       cell_next [SLOTS];
  logic [SLOTS-1:0] wr_sel;
  cell_t       tail;
  cell_ctl_t   ctl;

  // Sequencer.
  pst_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .out_o  (out_o),
    .head_i (cell_q[0]),
    .tail_o (tail),
    .ctl_o  (ctl)
  );

  // Row of cells: each takes its right neighbor's word, the last one takes the tail word.
  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    if (g == SLOTS - 1) begin : g_last
      assign cell_next[g] = tail;
    end else begin : g_mid
      assign cell_next[g] = cell_q[g+1];
    end

    assign wr_sel[g] = ctl.wr_en && (ctl.wr_idx == SLOT_W'(g));

    pst_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .shift_i     (ctl.shift),
      .load_i      (wr_sel[g]),
      .next_i      (cell_next[g]),
      .load_word_i (ctl.wr_word),
      .q_o         (cell_q[g])
    );
  end

endmodule
